// ----- hw/rtl/sxn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxn_pkg
// Shared types, constants and helpers of the 2-D simplex noise block.
// ----------------------------------------------------------------------------
package sxn_pkg;

  // fraction bits of coordinates and lattice offsets
  localparam int COORD_FRAC_BITS = 16;

  // permutation table geometry
  localparam int TABLE_AW   = 8;
  localparam int TABLE_SIZE = 1 << TABLE_AW;

  // skew / unskew factors in Q0.24
  localparam logic signed [32:0] F2_Q24 = 33'sd6140887;
  localparam logic signed [32:0] G2_Q24 = 33'sd3545443;

  // unskew offset of the middle corner in Q.16, and twice that
  localparam logic signed [23:0] G2_OFF  = 24'sd13849;
  localparam logic signed [23:0] G2_OFF2 = 24'sd27698;
  localparam logic signed [23:0] ONE_OFF = 24'(1 << COORD_FRAC_BITS);

  // 0.5 in Q.32 for the falloff term
  localparam logic signed [48:0] HALF_SQ = 49'(64'd1 << (2 * COORD_FRAC_BITS - 1));

  // gradient components in Q.16
  localparam logic signed [17:0] GRAD_ONE  = 18'(1 << COORD_FRAC_BITS);
  localparam logic signed [17:0] GRAD_DIAG = 18'sd46341;

  // number of quotient bits of the fractal divide
  localparam int QUO_BITS = 16;

  // input opcodes
  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_SAMPLE   = 2'd1,
    OP_FRACTAL  = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OCTAVES     = 2'd0,
    CFG_LACUNARITY  = 2'd1,
    CFG_PERSISTENCE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_e;

  // permutation table read request
  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
  } perm_rd_t;

  // x component of gradient g
  function automatic logic signed [17:0] grad_x(input logic [2:0] g);
    logic signed [17:0] v;
    unique case (g)
      3'd0:    v = GRAD_ONE;
      3'd1:    v = -GRAD_ONE;
      3'd4:    v = GRAD_DIAG;
      3'd5:    v = -GRAD_DIAG;
      3'd6:    v = GRAD_DIAG;
      3'd7:    v = -GRAD_DIAG;
      default: v = '0;
    endcase
    return v;
  endfunction

  // y component of gradient g
  function automatic logic signed [17:0] grad_y(input logic [2:0] g);
    logic signed [17:0] v;
    unique case (g)
      3'd2:    v = GRAD_ONE;
      3'd3:    v = -GRAD_ONE;
      3'd4:    v = GRAD_DIAG;
      3'd5:    v = GRAD_DIAG;
      3'd6:    v = -GRAD_DIAG;
      3'd7:    v = -GRAD_DIAG;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/sxn_perm_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxn_perm_mem
// Permutation table memory, one write and one registered read port, with an
// identity fill sweep after reset.
// ----------------------------------------------------------------------------
module sxn_perm_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [sxn_pkg::TABLE_AW-1:0] wr_addr_i,
  input  logic [7:0]                   wr_data_i,
  input  sxn_pkg::perm_rd_t            rd_i,
  output logic [7:0]                   rd_data_o,
  output logic                         init_busy_o
);

  logic [7:0]                 mem_q [sxn_pkg::TABLE_SIZE];
  logic [sxn_pkg::TABLE_AW:0] fill_q;
  logic [sxn_pkg::TABLE_AW:0] fill_d;
  logic                       filling;

  assign filling     = !fill_q[sxn_pkg::TABLE_AW];
  assign init_busy_o = filling;
  assign fill_d      = fill_q + 1'b1;

  // fill sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (filling) begin
      fill_q <= fill_d;
    end
  end

  // memory array: identity fill first, then item writes
  always_ff @(posedge clk_i) begin
    if (filling) begin
      mem_q[fill_q[sxn_pkg::TABLE_AW-1:0]] <= 8'(fill_q[sxn_pkg::TABLE_AW-1:0]);
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem_q[rd_i.addr];
    end
  end

endmodule

// ----- hw/rtl/sxn_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxn_div
// Restoring divider for the fractal average: one quotient bit per cycle,
// truncation toward zero, positive results saturated to 16 bits.
// ----------------------------------------------------------------------------
module sxn_div #(
  parameter int N_W = 52,
  parameter int D_W = 36
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [N_W-1:0] num_i,
  input  logic        [D_W-1:0] den_i,
  output logic                  done_o,
  output logic signed [15:0]    quo_o
);

  localparam int QB = sxn_pkg::QUO_BITS;
  localparam int CW = (N_W > D_W + QB) ? N_W : D_W + QB;

  logic                  run_q;
  logic [$clog2(QB)-1:0] k_q;
  logic [CW-1:0]         rem_q;
  logic [D_W-1:0]        den_q;
  logic                  neg_q;
  logic [QB-1:0]         quo_q;
  logic                  done_q;
  logic signed [15:0]    res_q;
  logic [N_W-1:0]        mag;
  logic [CW-1:0]         shifted;
  logic                  fits;
  logic [QB-1:0]         quo_d;
  logic [QB:0]           neg_quo;

  assign mag     = num_i[N_W-1] ? N_W'(-num_i) : N_W'(num_i);
  assign shifted = CW'(den_q) << k_q;
  assign fits    = rem_q >= shifted;

  // quotient with the current bit folded in
  always_comb begin
    quo_d      = quo_q;
    quo_d[k_q] = fits;
  end

  assign neg_quo = -{1'b0, quo_d};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (k_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && (k_q == '0)) begin
        run_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CW'(mag);
      den_q <= den_i;
      neg_q <= num_i[N_W-1];
      quo_q <= '0;
      k_q   <= '1;
    end else if (run_q) begin
      if (fits) begin
        rem_q <= rem_q - shifted;
      end
      quo_q <= quo_d;
      k_q   <= k_q - 1'b1;
      if (k_q == '0) begin
        if (neg_q) begin
          res_q <= 16'(neg_quo);
        end else if (quo_d[QB-1]) begin
          res_q <= 16'sh7fff;
        end else begin
          res_q <= 16'(quo_d);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

// ----- hw/rtl/sxn_noise.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxn_noise
// One simplex noise sample: skew, cell lookup through the permutation
// memory, three corner contributions on a shared multiplier, scale by 70.
// ----------------------------------------------------------------------------
module sxn_noise (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  output sxn_pkg::perm_rd_t  perm_rd_o,
  input  logic [7:0]         perm_data_i,
  output logic               done_o,
  output logic signed [15:0] value_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SKEW = 5'd1;
  localparam logic [4:0] ST_IJ   = 5'd2;
  localparam logic [4:0] ST_UNSK = 5'd3;
  localparam logic [4:0] ST_OFF  = 5'd4;
  localparam logic [4:0] ST_OFF2 = 5'd5;
  localparam logic [4:0] ST_R3   = 5'd6;
  localparam logic [4:0] ST_R4   = 5'd7;
  localparam logic [4:0] ST_R5   = 5'd8;
  localparam logic [4:0] ST_R6   = 5'd9;
  localparam logic [4:0] ST_DX2  = 5'd10;
  localparam logic [4:0] ST_DY2  = 5'd11;
  localparam logic [4:0] ST_T    = 5'd12;
  localparam logic [4:0] ST_T2   = 5'd13;
  localparam logic [4:0] ST_T3   = 5'd14;
  localparam logic [4:0] ST_GX   = 5'd15;
  localparam logic [4:0] ST_GY   = 5'd16;
  localparam logic [4:0] ST_DOT  = 5'd17;
  localparam logic [4:0] ST_TD   = 5'd18;
  localparam logic [4:0] ST_ACC  = 5'd19;
  localparam logic [4:0] ST_SCL  = 5'd20;

  logic [4:0]         state_q, state_d;
  logic               done_q;
  logic signed [31:0] x_q, y_q;
  logic signed [65:0] p_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [18:0] i_q, j_q;
  logic signed [23:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic               i1_q;
  logic [7:0]         a_q, b_q, c_q;
  logic [2:0]         g0_q, g1_q, gc_q;
  logic [1:0]         corner_q;
  logic signed [48:0] tq_q;
  logic [16:0]        tt_q;
  logic signed [41:0] gd_q;
  logic signed [26:0] dot_q;
  logic signed [47:0] acc_q;
  logic signed [15:0] value_q;

  logic signed [32:0] skew;
  logic signed [34:0] xs, ys;
  logic signed [42:0] unskew;
  logic signed [43:0] x0w, y0w;
  logic signed [23:0] dx_s, dy_s;
  logic [2:0]         g_s;
  logic signed [48:0] t_full;
  logic signed [42:0] dsum;
  logic signed [55:0] s70;
  logic signed [37:0] r_scl;
  logic               last_corner;

  // lattice cell and first offsets
  assign skew   = p_q[56:24];
  assign xs     = 35'(x_q) + 35'(skew);
  assign ys     = 35'(y_q) + 35'(skew);
  assign unskew = p_q[50:8];
  assign x0w    = 44'(x_q) - 44'({i_q, 16'd0}) + 44'(unskew);
  assign y0w    = 44'(y_q) - 44'({j_q, 16'd0}) + 44'(unskew);

  // corner selection
  always_comb begin
    unique case (corner_q)
      2'd0: begin
        dx_s = x0_q;
        dy_s = y0_q;
        g_s  = g0_q;
      end
      2'd1: begin
        dx_s = x1_q;
        dy_s = y1_q;
        g_s  = g1_q;
      end
      default: begin
        dx_s = x2_q;
        dy_s = y2_q;
        g_s  = gc_q;
      end
    endcase
  end

  assign last_corner = corner_q == 2'd2;
  assign t_full      = tq_q - 49'(p_q[47:0]);
  assign dsum        = 43'(gd_q) + 43'($signed(p_q[41:0]));
  assign s70         = (56'(acc_q) <<< 6) + (56'(acc_q) <<< 2) + (56'(acc_q) <<< 1);
  assign r_scl       = s70[55:18];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SKEW: begin
        mul_a = 33'(x_q) + 33'(y_q);
        mul_b = sxn_pkg::F2_Q24;
      end
      ST_UNSK: begin
        mul_a = 33'(i_q) + 33'(j_q);
        mul_b = sxn_pkg::G2_Q24;
      end
      ST_DX2: begin
        mul_a = 33'(dx_s);
        mul_b = 33'(dx_s);
      end
      ST_DY2: begin
        mul_a = 33'(dy_s);
        mul_b = 33'(dy_s);
      end
      ST_T2: begin
        mul_a = $signed({16'd0, tt_q});
        mul_b = $signed({16'd0, tt_q});
      end
      ST_T3: begin
        mul_a = $signed({16'd0, p_q[32:16]});
        mul_b = $signed({16'd0, p_q[32:16]});
      end
      ST_GX: begin
        mul_a = 33'(sxn_pkg::grad_x(g_s));
        mul_b = 33'(dx_s);
      end
      ST_GY: begin
        mul_a = 33'(sxn_pkg::grad_y(g_s));
        mul_b = 33'(dy_s);
      end
      ST_TD: begin
        mul_a = $signed({16'd0, tt_q});
        mul_b = 33'(dot_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // permutation reads: row entries, then gradient entries
  always_comb begin
    perm_rd_o.en   = 1'b1;
    perm_rd_o.addr = '0;
    unique case (state_q)
      ST_UNSK: perm_rd_o.addr = j_q[7:0];
      ST_OFF:  perm_rd_o.addr = j_q[7:0] + 8'd1;
      ST_OFF2: perm_rd_o.addr = j_q[7:0] + {7'd0, !i1_q};
      ST_R3:   perm_rd_o.addr = i_q[7:0] + a_q;
      ST_R4:   perm_rd_o.addr = i_q[7:0] + {7'd0, i1_q} + b_q;
      ST_R5:   perm_rd_o.addr = i_q[7:0] + 8'd1 + c_q;
      default: perm_rd_o.en   = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SKEW;
      ST_SKEW: state_d = ST_IJ;
      ST_IJ:   state_d = ST_UNSK;
      ST_UNSK: state_d = ST_OFF;
      ST_OFF:  state_d = ST_OFF2;
      ST_OFF2: state_d = ST_R3;
      ST_R3:   state_d = ST_R4;
      ST_R4:   state_d = ST_R5;
      ST_R5:   state_d = ST_R6;
      ST_R6:   state_d = ST_DX2;
      ST_DX2:  state_d = ST_DY2;
      ST_DY2:  state_d = ST_T;
      ST_T: begin
        if (!t_full[48]) begin
          state_d = ST_T2;
        end else if (last_corner) begin
          state_d = ST_SCL;
        end else begin
          state_d = ST_DX2;
        end
      end
      ST_T2:   state_d = ST_T3;
      ST_T3:   state_d = ST_GX;
      ST_GX:   state_d = ST_GY;
      ST_GY:   state_d = ST_DOT;
      ST_DOT:  state_d = ST_TD;
      ST_TD:   state_d = ST_ACC;
      ST_ACC:  state_d = last_corner ? ST_SCL : ST_DX2;
      ST_SCL:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == ST_SCL;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= 66'(mul_a * mul_b);
    unique case (state_q)
      ST_IDLE: begin
        x_q <= x_i;
        y_q <= y_i;
      end
      ST_IJ: begin
        i_q <= xs[34:16];
        j_q <= ys[34:16];
      end
      ST_OFF: begin
        x0_q <= x0w[23:0];
        y0_q <= y0w[23:0];
        i1_q <= $signed(x0w[23:0]) > $signed(y0w[23:0]);
        a_q  <= perm_data_i;
      end
      ST_OFF2: begin
        x1_q <= x0_q - (i1_q ? sxn_pkg::ONE_OFF : 24'sd0) + sxn_pkg::G2_OFF;
        y1_q <= y0_q - (i1_q ? 24'sd0 : sxn_pkg::ONE_OFF) + sxn_pkg::G2_OFF;
        x2_q <= x0_q - sxn_pkg::ONE_OFF + sxn_pkg::G2_OFF2;
        y2_q <= y0_q - sxn_pkg::ONE_OFF + sxn_pkg::G2_OFF2;
        c_q  <= perm_data_i;
      end
      ST_R3: b_q  <= perm_data_i;
      ST_R4: g0_q <= perm_data_i[2:0];
      ST_R5: g1_q <= perm_data_i[2:0];
      ST_R6: begin
        gc_q     <= perm_data_i[2:0];
        corner_q <= 2'd0;
        acc_q    <= '0;
      end
      ST_DY2: tq_q <= sxn_pkg::HALF_SQ - 49'(p_q[47:0]);
      ST_T: begin
        tt_q <= t_full[32:16];
        if (t_full[48]) begin
          corner_q <= corner_q + 2'd1;
        end
      end
      ST_GX:  tt_q  <= p_q[32:16];
      ST_GY:  gd_q  <= $signed(p_q[41:0]);
      ST_DOT: dot_q <= dsum[42:16];
      ST_ACC: begin
        acc_q    <= acc_q + $signed(p_q[47:0]);
        corner_q <= corner_q + 2'd1;
      end
      ST_SCL: begin
        if (r_scl > 38'sd32767) begin
          value_q <= 16'sh7fff;
        end else if (r_scl < -38'sd32768) begin
          value_q <= 16'sh8000;
        end else begin
          value_q <= r_scl[15:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

// ----- hw/rtl/simplex_noise_2d_fbm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_noise_2d_fbm
// 2-D simplex noise and fractal sum over a 256-byte permutation table.
// ----------------------------------------------------------------------------
// After reset the table is filled with the identity, busy high throughout.
// A single sample is taken from the accepting edge to the result strobe in
// these steps: skew and six permutation memory reads, then the work of each
// corner on the one shared multiplier, scaling, the done flag and the result
// register. A fractal sum takes per octave the sequencer steps and a sample,
// then the bit-serial divider, and strobes in the cycle after the divider
// finishes; zero octaves strobe in the cycle after the accept. The result is
// on noise_value_o for the single cycle that noise_valid_o is high and is not
// held: the receiver cannot stall it.
// Register writes are taken only while the block is idle.
module simplex_noise_2d_fbm #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               noise_valid_o,
  output logic signed [15:0] noise_value_o
);

  localparam int K_W    = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W  = 48 + K_W;
  localparam int ASUM_W = 32 + K_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NWAIT = 4'd1;
  localparam logic [3:0] ST_FSX   = 4'd2;
  localparam logic [3:0] ST_FSY   = 4'd3;
  localparam logic [3:0] ST_FSYC  = 4'd4;
  localparam logic [3:0] ST_FNS   = 4'd5;
  localparam logic [3:0] ST_FNW   = 4'd6;
  localparam logic [3:0] ST_FACC  = 4'd7;
  localparam logic [3:0] ST_FADD  = 4'd8;
  localparam logic [3:0] ST_FAMP  = 4'd9;
  localparam logic [3:0] ST_FFRQ  = 4'd10;
  localparam logic [3:0] ST_DWAIT = 4'd11;

  localparam logic signed [53:0] INT32_MAX = 54'sd2147483647;
  localparam logic signed [53:0] INT32_MIN = -54'sd2147483648;

  logic [3:0]             state_q, state_d;
  logic [3:0]             oct_q;
  logic [15:0]            lac_q, pers_q;
  logic                   out_valid_q;
  logic signed [15:0]     out_value_q;
  logic signed [31:0]     xr_q, yr_q, sx_q, sy_q;
  logic [31:0]            freq_q, amp_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [ASUM_W-1:0]      asum_q;
  logic [K_W-1:0]         n_q, k_q, n_sel;
  logic signed [15:0]     nv_q;
  logic signed [65:0]     p_q;
  logic signed [32:0]     mul_a, mul_b;
  logic signed [53:0]     p_sh;
  logic signed [31:0]     p_sat;
  logic [31:0]            p_cap;

  logic                   accept;
  logic                   cfg_we;
  logic                   mem_busy;
  sxn_pkg::opcode_e       op;
  sxn_pkg::perm_rd_t      perm_rd;
  logic [7:0]             perm_data;
  logic                   noise_start;
  logic signed [31:0]     noise_x, noise_y;
  logic                   noise_done;
  logic signed [15:0]     noise_val;
  logic                   div_start;
  logic                   div_done;
  logic signed [15:0]     div_val;

  assign op          = sxn_pkg::opcode_e'(opcode_i);
  assign busy        = (state_q != ST_IDLE) || mem_busy;
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // octave count clamped to the supported maximum
  assign n_sel = (32'(oct_q) > MAX_OCTAVES) ? K_W'(MAX_OCTAVES) : K_W'(oct_q);

  // scaled product, saturated forms
  assign p_sh  = p_q[65:12];
  assign p_sat = (p_sh > INT32_MAX) ? 32'h7fffffff :
                 (p_sh < INT32_MIN) ? 32'h80000000 : p_sh[31:0];
  assign p_cap = (p_sh > INT32_MAX) ? 32'h7fffffff : p_sh[31:0];

  // noise unit feed
  assign noise_start = (accept && (op == sxn_pkg::OP_SAMPLE)) || (state_q == ST_FNS);
  assign noise_x     = (state_q == ST_IDLE) ? x_coord_i : sx_q;
  assign noise_y     = (state_q == ST_IDLE) ? y_coord_i : sy_q;
  assign div_start   = (state_q == ST_FFRQ) && (k_q + 1'b1 == n_q);

  sxn_perm_mem u_perm_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (accept && (op == sxn_pkg::OP_WRITE)),
    .wr_addr_i   (table_index_i),
    .wr_data_i   (table_value_i),
    .rd_i        (perm_rd),
    .rd_data_o   (perm_data),
    .init_busy_o (mem_busy)
  );

  sxn_noise u_noise (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (noise_start),
    .x_i         (noise_x),
    .y_i         (noise_y),
    .perm_rd_o   (perm_rd),
    .perm_data_i (perm_data),
    .done_o      (noise_done),
    .value_o     (noise_val)
  );

  sxn_div #(
    .N_W (SUM_W),
    .D_W (ASUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (asum_q),
    .done_o  (div_done),
    .quo_o   (div_val)
  );

  // fractal multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_FSX: begin
        mul_a = 33'(xr_q);
        mul_b = $signed({1'b0, freq_q});
      end
      ST_FSY: begin
        mul_a = 33'(yr_q);
        mul_b = $signed({1'b0, freq_q});
      end
      ST_FACC: begin
        mul_a = 33'(nv_q);
        mul_b = $signed({1'b0, amp_q});
      end
      ST_FADD: begin
        mul_a = $signed({1'b0, amp_q});
        mul_b = $signed({17'd0, pers_q});
      end
      ST_FAMP: begin
        mul_a = $signed({1'b0, freq_q});
        mul_b = $signed({17'd0, lac_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // item sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op == sxn_pkg::OP_SAMPLE)) begin
          state_d = ST_NWAIT;
        end else if (accept && (op == sxn_pkg::OP_FRACTAL) && (n_sel != '0)) begin
          state_d = ST_FSX;
        end
      end
      ST_NWAIT: if (noise_done) state_d = ST_IDLE;
      ST_FSX:   state_d = ST_FSY;
      ST_FSY:   state_d = ST_FSYC;
      ST_FSYC:  state_d = ST_FNS;
      ST_FNS:   state_d = ST_FNW;
      ST_FNW:   if (noise_done) state_d = ST_FACC;
      ST_FACC:  state_d = ST_FADD;
      ST_FADD:  state_d = ST_FAMP;
      ST_FAMP:  state_d = ST_FFRQ;
      ST_FFRQ:  state_d = div_start ? ST_DWAIT : ST_FSX;
      ST_DWAIT: if (div_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oct_q       <= 4'd4;
      lac_q       <= 16'd8192;
      pers_q      <= 16'd2048;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= ((state_q == ST_NWAIT) && noise_done) ||
                     ((state_q == ST_DWAIT) && div_done) ||
                     (accept && (op == sxn_pkg::OP_FRACTAL) && (n_sel == '0));
      if (cfg_we) begin
        unique case (sxn_pkg::cfg_index_e'(cfg_index_i))
          sxn_pkg::CFG_OCTAVES:     oct_q  <= cfg_data_i[3:0];
          sxn_pkg::CFG_LACUNARITY:  lac_q  <= cfg_data_i;
          sxn_pkg::CFG_PERSISTENCE: pers_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // fractal datapath and result register
  always_ff @(posedge clk_i) begin
    p_q <= 66'(mul_a * mul_b);
    if (state_q == ST_NWAIT) begin
      out_value_q <= noise_val;
    end else if (state_q == ST_DWAIT) begin
      out_value_q <= div_val;
    end else begin
      out_value_q <= '0;
    end
    unique case (state_q)
      ST_IDLE: begin
        xr_q   <= x_coord_i;
        yr_q   <= y_coord_i;
        n_q    <= n_sel;
        k_q    <= '0;
        freq_q <= 32'd4096;
        amp_q  <= 32'd4096;
        sum_q  <= '0;
        asum_q <= '0;
      end
      ST_FSY:  sx_q <= p_sat;
      ST_FSYC: sy_q <= p_sat;
      ST_FNW:  nv_q <= noise_val;
      ST_FADD: begin
        sum_q  <= sum_q + SUM_W'($signed(p_q[47:0]));
        asum_q <= asum_q + ASUM_W'(amp_q);
      end
      ST_FAMP: amp_q <= p_cap;
      ST_FFRQ: begin
        freq_q <= p_cap;
        k_q    <= k_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign noise_valid_o = out_valid_q;
  assign noise_value_o = out_value_q;

  // table fill sweep keeps items out
  ap_fill_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> busy)
    else $error("item could be accepted during table fill");

  // divider finishes only while the sequencer waits for it
  ap_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DWAIT))
    else $error("divider done outside its wait state");

  // noise unit finishes only while the sequencer waits for it
  ap_noise_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_done |-> ((state_q == ST_NWAIT) || (state_q == ST_FNW)))
    else $error("noise sample done outside a wait state");

endmodule
